// ===== rtl/rgb2hsl_pkg.sv =====
// shared types, constants and the division step for the rgb to hsl pixel unit
package rgb2hsl_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;
  } pixel_out_t;

  localparam logic [1:0] DOM_RED   = 2'd0;
  localparam logic [1:0] DOM_GREEN = 2'd1;
  localparam logic [1:0] DOM_BLUE  = 2'd2;

  localparam int unsigned DIV_STEPS = 8;

  localparam logic [8:0] DEG_GREEN = 9'd120;
  localparam logic [8:0] DEG_BLUE  = 9'd240;
  localparam logic [8:0] DEG_FULL  = 9'd360;
  localparam logic [8:0] DEN_FOLD  = 9'd510;

  // floor(y / 3) = (y * 683) >> 11 for y below 768
  localparam logic [9:0] RECIP_THIRD = 10'd683;

  // one restoring divider lane: partial remainder, numerator bits still to
  // bring down, quotient bits so far
  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] low;
    logic [7:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [7:0] light;
    logic       grey;
    logic [1:0] dom;
    logic       neg;
    logic [7:0] sat_den;
    logic [7:0] hue_den;
    div_lane_t  sat;
    div_lane_t  hue;
  } div_stage_t;

  function automatic div_lane_t div_step(div_lane_t s, logic [7:0] den);
    logic [8:0] t;
    div_lane_t  n;
    t     = {s.rem, s.low[7]};
    n.low = {s.low[6:0], 1'b0};
    if (t >= {1'b0, den}) begin
      n.rem = 8'(t - {1'b0, den});
      n.quo = {s.quo[6:0], 1'b1};
    end else begin
      n.rem = t[7:0];
      n.quo = {s.quo[6:0], 1'b0};
    end
    return n;
  endfunction

endpackage

// ===== rtl/rgb_to_hsl_pixel_unit.sv =====
// rgb to hsl pixel converter: twelve-stage pipeline with two bit-serial dividers
// One pixel may be started in every clock cycle and busy never rises; each
// result leaves on out_pixel with out_valid high for a single cycle exactly 12
// cycles after its start, in start order, and must be taken then since the
// receiver cannot stall. The latency is set by the two 8-bit restoring
// dividers (saturation and hue), which produce one quotient bit per stage,
// plus a min/max stage, a numerator stage, a hue angle stage and an output
// stage that scales degrees to the 0..254 hue byte. Grey pixels give zero
// hue and saturation.
module rgb_to_hsl_pixel_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  rgb2hsl_pkg::pixel_in_t  in_pixel,
  output logic                   out_valid,
  output rgb2hsl_pkg::pixel_out_t out_pixel
);
  import rgb2hsl_pkg::*;

  localparam int unsigned LATENCY = DIV_STEPS + 4;

  // front stage: max, min, dominant channel, hue difference
  logic       s1_vld_r;
  logic [7:0] s1_light_r, s1_d_r, s1_den_r, s1_abs_r;
  logic       s1_grey_r, s1_neg_r;
  logic [1:0] s1_dom_r;

  logic [7:0] mx, mn;
  logic [8:0] sum, den_w;
  logic [8:0] diff;
  logic [1:0] dom;

  always_comb begin
    mx = in_pixel.red;
    mn = in_pixel.red;
    if (in_pixel.green > mx) mx = in_pixel.green;
    if (in_pixel.blue  > mx) mx = in_pixel.blue;
    if (in_pixel.green < mn) mn = in_pixel.green;
    if (in_pixel.blue  < mn) mn = in_pixel.blue;
    sum   = {1'b0, mx} + {1'b0, mn};
    den_w = (sum <= 9'd255) ? sum : (DEN_FOLD - sum);
    priority if (mx == in_pixel.red) begin
      dom  = DOM_RED;
      diff = {1'b0, in_pixel.green} - {1'b0, in_pixel.blue};
    end else if (mx == in_pixel.green) begin
      dom  = DOM_GREEN;
      diff = {1'b0, in_pixel.blue} - {1'b0, in_pixel.red};
    end else begin
      dom  = DOM_BLUE;
      diff = {1'b0, in_pixel.red} - {1'b0, in_pixel.green};
    end
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_light_r <= sum[8:1];
    s1_d_r     <= mx - mn;
    s1_grey_r  <= (mx == mn);
    s1_den_r   <= den_w[7:0];
    s1_dom_r   <= dom;
    s1_neg_r   <= diff[8];
    s1_abs_r   <= diff[8] ? 8'(-diff) : diff[7:0];
  end

  // numerators and divider setup, grey forces harmless divisors
  logic [7:0]  sat_den, hue_den;
  logic [15:0] sat_num, hue_num;
  div_stage_t  dv_nxt [0:DIV_STEPS];
  div_stage_t  dv_r   [0:DIV_STEPS];
  logic [DIV_STEPS:0] dv_vld_r;

  always_comb begin
    sat_den = s1_grey_r ? 8'd1 : s1_den_r;
    hue_den = s1_grey_r ? 8'd1 : s1_d_r;
    sat_num = s1_grey_r ? 16'd0 : ({s1_d_r, 8'd0} - {8'd0, s1_d_r});
    hue_num = s1_grey_r ? 16'd0 : ({2'b00, s1_abs_r, 6'd0} - {6'd0, s1_abs_r, 2'b00});
    dv_nxt[0].light   = s1_light_r;
    dv_nxt[0].grey    = s1_grey_r;
    dv_nxt[0].dom     = s1_dom_r;
    dv_nxt[0].neg     = s1_neg_r;
    dv_nxt[0].sat_den = sat_den;
    dv_nxt[0].hue_den = hue_den;
    dv_nxt[0].sat     = '{rem: sat_num[15:8], low: sat_num[7:0], quo: 8'd0};
    dv_nxt[0].hue     = '{rem: hue_num[15:8], low: hue_num[7:0], quo: 8'd0};
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    always_comb begin
      dv_nxt[k]     = dv_r[k-1];
      dv_nxt[k].sat = div_step(dv_r[k-1].sat, dv_r[k-1].sat_den);
      dv_nxt[k].hue = div_step(dv_r[k-1].hue, dv_r[k-1].hue_den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r <= '0;
    end else begin
      dv_vld_r <= {dv_vld_r[DIV_STEPS-1:0], s1_vld_r};
    end
    for (int i = 0; i <= DIV_STEPS; i++) begin
      dv_r[i] <= dv_nxt[i];
    end
  end

  // hue angle in degrees, then times 17
  div_stage_t dq;
  logic [8:0]  adj, deg;
  logic [12:0] prod17_nxt;
  logic        hs_vld_r;
  logic [12:0] prod17_r;
  logic [7:0]  hs_sat_r, hs_light_r;

  always_comb begin
    dq  = dv_r[DIV_STEPS];
    adj = {1'b0, dq.hue.quo} + {8'd0, (dq.hue.rem != 8'd0)};
    unique case (dq.dom)
      DOM_RED:   deg = dq.neg ? (DEG_FULL - adj) : {1'b0, dq.hue.quo};
      DOM_GREEN: deg = dq.neg ? (DEG_GREEN - adj) : (DEG_GREEN + {1'b0, dq.hue.quo});
      DOM_BLUE:  deg = dq.neg ? (DEG_BLUE - adj) : (DEG_BLUE + {1'b0, dq.hue.quo});
      default:   deg = 9'd0;
    endcase
    if (dq.grey) deg = 9'd0;
    prod17_nxt = {deg, 4'd0} + {4'd0, deg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_vld_r <= 1'b0;
    end else begin
      hs_vld_r <= dv_vld_r[DIV_STEPS];
    end
    prod17_r   <= prod17_nxt;
    hs_sat_r   <= dq.grey ? 8'd0 : dq.sat.quo;
    hs_light_r <= dq.light;
  end

  // deg * 255 / 360 = ((deg * 17) >> 3) / 3
  logic [19:0] third;
  logic        out_vld_r;
  pixel_out_t  out_r;

  assign third = {10'd0, prod17_r[12:3]} * {10'd0, RECIP_THIRD};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= hs_vld_r;
    end
    out_r.hue        <= third[18:11];
    out_r.saturation <= hs_sat_r;
    out_r.lightness  <= hs_light_r;
  end

  assign out_valid = out_vld_r;
  assign out_pixel = out_r;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("started item did not come out after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    !start |-> ##LATENCY !out_valid)
    else $error("result strobe without a started item");

  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel.hue <= 8'd254))
    else $error("hue byte out of range");

  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld_r[DIV_STEPS] |-> (dq.sat.rem < dq.sat_den) && (dq.hue.rem < dq.hue_den))
    else $error("divider remainder not below divisor");

endmodule
